[rtl/poac_pkg.sv]
`default_nettype none
package poac_pkg;

	localparam int BLOCK_ID_W = 8;
	localparam int LEAF_PORT_W = 7;
	localparam int COUNT_PORT_W = 7;
	localparam int THRESH_W = 7;

	localparam logic [1:0] FUNC_ACCESS  = 2'd0;
	localparam logic [1:0] FUNC_DUMMY   = 2'd1;
	localparam logic [1:0] FUNC_INSTALL = 2'd2;
	localparam logic [1:0] FUNC_UNUSED  = 2'd3;

	localparam logic CFG_UPPER = 1'b0;
	localparam logic CFG_LOWER = 1'b1;

	localparam logic [6:0] UPPER_RESET = 7'd48;
	localparam logic [6:0] LOWER_RESET = 7'd16;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_DECODE,
		OP_RP_FILLW,
		OP_RP_PUSH,
		OP_RP_NEXT,
		OP_EV_FILLW,
		OP_EV_RD,
		OP_EV_LM,
		OP_EV_CMP,
		OP_EV_END,
		OP_FINISH
	} poac_op_t;

	typedef struct packed {
		logic clear_done;
		logic invalid;
		logic install;
		logic fill_zero;
		logic slot_last;
		logic level_zero;
		logic scan_end;
		logic skip_rest;
		logic bucket_full;
		logic out_free;
	} poac_status_t;

endpackage
`default_nettype wire

[rtl/poac_ctrl.sv]
`default_nettype none
module poac_ctrl
	import poac_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire poac_status_t status,
	output poac_op_t          op
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_RP_FILL,
		S_RP_FILLW,
		S_RP_SLOT,
		S_RP_PUSH,
		S_RP_NEXT,
		S_EV_FILL,
		S_EV_FILLW,
		S_EV_RD,
		S_EV_LM,
		S_EV_CMP,
		S_EV_END,
		S_FINISH
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		case (state_q)
			S_CLEAR:    op = OP_CLEAR;
			S_IDLE:     op = in_valid ? OP_LOAD : OP_NONE;
			S_DECODE:   op = OP_DECODE;
			S_RP_FILLW: op = OP_RP_FILLW;
			S_RP_PUSH:  op = OP_RP_PUSH;
			S_RP_NEXT:  op = OP_RP_NEXT;
			S_EV_FILLW: op = OP_EV_FILLW;
			S_EV_RD:    op = OP_EV_RD;
			S_EV_LM:    op = OP_EV_LM;
			S_EV_CMP:   op = OP_EV_CMP;
			S_EV_END:   op = OP_EV_END;
			S_FINISH:   op = OP_FINISH;
			default:    op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (status.clear_done) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					if (status.invalid) state_q <= S_FINISH;
					else if (status.install) state_q <= S_EV_FILL;
					else state_q <= S_RP_FILL;
				end
				S_RP_FILL:  state_q <= S_RP_FILLW;
				S_RP_FILLW: state_q <= status.fill_zero ? S_RP_NEXT : S_RP_SLOT;
				S_RP_SLOT:  state_q <= S_RP_PUSH;
				S_RP_PUSH:  state_q <= status.slot_last ? S_RP_NEXT : S_RP_SLOT;
				S_RP_NEXT:  state_q <= status.level_zero ? S_EV_FILL : S_RP_FILL;
				S_EV_FILL:  state_q <= S_EV_FILLW;
				S_EV_FILLW: state_q <= S_EV_RD;
				S_EV_RD: begin
					if (status.scan_end || status.skip_rest) state_q <= S_EV_END;
					else state_q <= S_EV_LM;
				end
				S_EV_LM:  state_q <= status.bucket_full ? S_EV_RD : S_EV_CMP;
				S_EV_CMP: state_q <= S_EV_RD;
				S_EV_END: state_q <= status.level_zero ? S_FINISH : S_EV_FILL;
				S_FINISH: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/poac_datapath.sv]
`default_nettype none
module poac_datapath
	import poac_pkg::*;
#(
	parameter int TREE_LEVELS  = 8,
	parameter int BUCKET_SLOTS = 3,
	parameter int NUM_BLOCKS   = 256,
	parameter int STASH_DEPTH  = 64
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire poac_op_t                op,
	output poac_status_t                 status,
	input  wire logic                    cfg_write,
	input  wire logic                    cfg_index,
	input  wire logic [THRESH_W-1:0]     cfg_data,
	input  wire logic [1:0]              func,
	input  wire logic [BLOCK_ID_W-1:0]   block_id,
	input  wire logic [LEAF_PORT_W-1:0]  new_leaf,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [LEAF_PORT_W-1:0]       path_leaf,
	output logic [COUNT_PORT_W-1:0]      stash_count,
	output logic                         stash_overflow,
	output logic                         dummy_needed
);

	localparam int LEAF_W     = TREE_LEVELS - 1;
	localparam int NODE_W     = TREE_LEVELS;
	localparam int NODE_COUNT = (1 << TREE_LEVELS) - 1;
	localparam int LV_W       = $clog2(TREE_LEVELS);
	localparam int SL_W       = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
	localparam int FL_W       = $clog2(BUCKET_SLOTS + 1);
	localparam int SI_W       = $clog2(STASH_DEPTH);
	localparam int SC_W       = $clog2(STASH_DEPTH + 1);
	localparam int LM_AW      = $clog2(NUM_BLOCKS);
	localparam int SA_W       = NODE_W + SL_W;

	logic [THRESH_W-1:0]   upper_q, lower_q;
	logic [NODE_W-1:0]     clr_q;
	logic [1:0]            func_q;
	logic [BLOCK_ID_W-1:0] blk_q, cur_blk_q;
	logic [LEAF_W-1:0]     nleaf_q, path_q;
	logic                  invalid_q, dropped_q, draining_q;
	logic [LV_W-1:0]       level_q;
	logic [FL_W-1:0]       fill_q;
	logic [SL_W-1:0]       slot_q;
	logic [SC_W-1:0]       used_q, k_q, w_q;
	logic                  out_valid_q;

	// memories
	logic [FL_W-1:0]       fill_mem [NODE_COUNT];
	logic [BLOCK_ID_W-1:0] slot_mem [2**SA_W];
	logic [LEAF_W-1:0]     lm_mem [NUM_BLOCKS];
	logic [BLOCK_ID_W-1:0] stash_mem [STASH_DEPTH];
	logic [FL_W-1:0]       fill_rdata;
	logic [BLOCK_ID_W-1:0] slot_rdata, stash_rdata;
	logic [LEAF_W-1:0]     lm_rdata;

	logic [LV_W-1:0]       shift;
	logic [NODE_W-1:0]     node;
	logic                  match, push_ok, level_zero, out_free, bucket_full, in_bad;
	logic [LM_AW-1:0]      lm_raddr, lm_waddr;
	logic                  fill_we, st_we, sl_we, lm_we;
	logic [NODE_W-1:0]     fill_waddr;
	logic [FL_W-1:0]       fill_wdata;
	logic [SI_W-1:0]       st_waddr;
	logic [BLOCK_ID_W-1:0] st_wdata;

	assign shift = LV_W'(TREE_LEVELS - 1) - level_q;
	// node index of this level on the current path
	assign node = ((NODE_W'(1) << level_q) - NODE_W'(1)) + (NODE_W'(path_q) >> shift);
	assign match = (lm_rdata >> shift) == (path_q >> shift);
	assign push_ok = used_q != SC_W'(STASH_DEPTH);
	assign level_zero = level_q == '0;
	assign out_free = !out_valid_q || out_ready;
	assign bucket_full = fill_q == FL_W'(BUCKET_SLOTS);
	assign in_bad = (func == FUNC_UNUSED) || (32'(block_id) >= 32'(NUM_BLOCKS));
	assign lm_raddr = (op == OP_LOAD) ? LM_AW'(block_id) : LM_AW'(stash_rdata);
	assign lm_waddr = LM_AW'(blk_q);

	assign status.clear_done  = clr_q == NODE_W'(NODE_COUNT - 1);
	assign status.invalid     = invalid_q;
	assign status.install     = func_q == FUNC_INSTALL;
	assign status.fill_zero   = fill_rdata == '0;
	assign status.slot_last   = (32'(slot_q) + 32'd1) >= 32'(fill_q);
	assign status.level_zero  = level_zero;
	assign status.scan_end    = k_q == used_q;
	assign status.skip_rest   = bucket_full && (w_q == k_q);
	assign status.bucket_full = bucket_full;
	assign status.out_free    = out_free;

	assign out_valid = out_valid_q;

	always_comb begin
		fill_we = 1'b0;
		fill_waddr = node;
		fill_wdata = '0;
		st_we = 1'b0;
		st_waddr = used_q[SI_W-1:0];
		st_wdata = blk_q;
		sl_we = 1'b0;
		lm_we = 1'b0;
		case (op)
			OP_CLEAR: begin
				fill_we = 1'b1;
				fill_waddr = clr_q;
			end
			OP_DECODE: begin
				if (!invalid_q && func_q == FUNC_INSTALL) begin
					lm_we = 1'b1;
					st_we = push_ok;
				end
			end
			OP_RP_FILLW: fill_we = 1'b1;
			OP_RP_PUSH: begin
				st_we = push_ok;
				st_wdata = slot_rdata;
			end
			OP_RP_NEXT: lm_we = level_zero && (func_q == FUNC_ACCESS);
			OP_EV_LM: begin
				// bucket full: only close the gap left by removed entries
				st_we = bucket_full;
				st_waddr = w_q[SI_W-1:0];
				st_wdata = stash_rdata;
			end
			OP_EV_CMP: begin
				sl_we = match;
				st_we = !match;
				st_waddr = w_q[SI_W-1:0];
				st_wdata = cur_blk_q;
			end
			OP_EV_END: begin
				fill_we = 1'b1;
				fill_wdata = fill_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		fill_rdata <= fill_mem[node];
		if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
		slot_rdata <= slot_mem[{node, slot_q}];
		if (sl_we) slot_mem[{node, SL_W'(fill_q)}] <= cur_blk_q;
		lm_rdata <= lm_mem[lm_raddr];
		if (lm_we) lm_mem[lm_waddr] <= nleaf_q;
		stash_rdata <= stash_mem[k_q[SI_W-1:0]];
		if (st_we) stash_mem[st_waddr] <= st_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= UPPER_RESET;
			lower_q <= LOWER_RESET;
			clr_q <= '0;
			func_q <= FUNC_UNUSED;
			blk_q <= '0;
			cur_blk_q <= '0;
			nleaf_q <= '0;
			path_q <= '0;
			invalid_q <= 1'b0;
			dropped_q <= 1'b0;
			draining_q <= 1'b0;
			level_q <= '0;
			fill_q <= '0;
			slot_q <= '0;
			used_q <= '0;
			k_q <= '0;
			w_q <= '0;
			out_valid_q <= 1'b0;
			path_leaf <= '0;
			stash_count <= '0;
			stash_overflow <= 1'b0;
			dummy_needed <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_UPPER: upper_q <= cfg_data;
					CFG_LOWER: lower_q <= cfg_data;
					default: ;
				endcase
			end
			if (op == OP_FINISH && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (op)
				OP_CLEAR: clr_q <= clr_q + NODE_W'(1);
				OP_LOAD: begin
					func_q <= func;
					blk_q <= block_id;
					nleaf_q <= LEAF_W'(new_leaf);
					invalid_q <= in_bad;
					dropped_q <= 1'b0;
					path_q <= '0;
					level_q <= LV_W'(TREE_LEVELS - 1);
				end
				OP_DECODE: begin
					if (!invalid_q) begin
						if (func_q == FUNC_INSTALL) begin
							path_q <= nleaf_q;
							if (push_ok) used_q <= used_q + SC_W'(1);
							else dropped_q <= 1'b1;
						end else begin
							path_q <= lm_rdata;
						end
					end
				end
				OP_RP_FILLW: begin
					fill_q <= fill_rdata;
					slot_q <= '0;
				end
				OP_RP_PUSH: begin
					if (push_ok) used_q <= used_q + SC_W'(1);
					else dropped_q <= 1'b1;
					slot_q <= slot_q + SL_W'(1);
				end
				OP_RP_NEXT: begin
					if (level_zero) level_q <= LV_W'(TREE_LEVELS - 1);
					else level_q <= level_q - LV_W'(1);
				end
				OP_EV_FILLW: begin
					fill_q <= fill_rdata;
					k_q <= '0;
					w_q <= '0;
				end
				OP_EV_RD: begin
					if (k_q == used_q) used_q <= w_q;
				end
				OP_EV_LM: begin
					if (bucket_full) begin
						w_q <= w_q + SC_W'(1);
						k_q <= k_q + SC_W'(1);
					end else begin
						cur_blk_q <= stash_rdata;
					end
				end
				OP_EV_CMP: begin
					if (match) fill_q <= fill_q + FL_W'(1);
					else w_q <= w_q + SC_W'(1);
					k_q <= k_q + SC_W'(1);
				end
				OP_EV_END: begin
					if (!level_zero) level_q <= level_q - LV_W'(1);
				end
				OP_FINISH: begin
					if (out_free) begin
						path_leaf <= LEAF_PORT_W'(path_q);
						stash_count <= COUNT_PORT_W'(used_q);
						stash_overflow <= dropped_q;
						if (32'(used_q) > 32'(upper_q)) begin
							draining_q <= 1'b1;
							dummy_needed <= 1'b1;
						end else if (32'(used_q) <= 32'(lower_q)) begin
							draining_q <= 1'b0;
							dummy_needed <= 1'b0;
						end else begin
							dummy_needed <= draining_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= SC_W'(STASH_DEPTH)) else $error("stash count beyond depth");
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		w_q <= k_q) else $error("stash write pointer ahead of read pointer");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FL_W'(BUCKET_SLOTS)) else $error("bucket overfilled");
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_FINISH && out_free) |=> out_valid_q) else $error("result lost");
`endif

endmodule
`default_nettype wire

[rtl/path_oram_access_controller.sv]
`default_nettype none
// path oram access controller
// input channel (in_valid/in_ready) carries func, block_id and new_leaf; one
// result transaction (out_valid/out_ready) follows every input transaction with
// path_leaf, stash_count, stash_overflow and dummy_needed.
// one transaction at a time. access/dummy: decode, read every bucket on the
// path into the stash, then evict level by level; install: decode, then evict
// level by level; unused func or bad id: straight to the result.
// the eviction scan dominates: one stash entry takes a stash read, a position
// map read and a compare/write at each eviction level.
// after reset a clearing pass zeroes the bucket fill counts of all
// 2^TREE_LEVELS - 1 nodes (255 by default); in_ready stays low until it ends.
// the result sits in an output register; a new transaction is taken while it
// waits, and the block stalls only when its next result is ready and the
// previous one has not been taken.
// cfg_write with cfg_index 0 sets the upper threshold, 1 the lower one; write
// only while idle.
module path_oram_access_controller
	import poac_pkg::*;
#(
	parameter int TREE_LEVELS  = 8,
	parameter int BUCKET_SLOTS = 3,
	parameter int NUM_BLOCKS   = 256,
	parameter int STASH_DEPTH  = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic                   cfg_index,
	input  wire logic [THRESH_W-1:0]    cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [1:0]             func,
	input  wire logic [BLOCK_ID_W-1:0]  block_id,
	input  wire logic [LEAF_PORT_W-1:0] new_leaf,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [LEAF_PORT_W-1:0]      path_leaf,
	output logic [COUNT_PORT_W-1:0]     stash_count,
	output logic                        stash_overflow,
	output logic                        dummy_needed
);

	poac_op_t     op;
	poac_status_t status;

	poac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.op       (op)
	);

	poac_datapath #(
		.TREE_LEVELS  (TREE_LEVELS),
		.BUCKET_SLOTS (BUCKET_SLOTS),
		.NUM_BLOCKS   (NUM_BLOCKS),
		.STASH_DEPTH  (STASH_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.status         (status),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.func           (func),
		.block_id       (block_id),
		.new_leaf       (new_leaf),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.path_leaf      (path_leaf),
		.stash_count    (stash_count),
		.stash_overflow (stash_overflow),
		.dummy_needed   (dummy_needed)
	);

endmodule
`default_nettype wire

[tb/sv/path_oram_access_controller_tb.sv]
`timescale 1ns / 1ps
module path_oram_access_controller_tb;
	import poac_pkg::*;

	localparam int LEVELS = 8;
	localparam int SLOTS = 3;
	localparam int NODES = (1 << LEVELS) - 1;
	localparam int STASH_MAX = 64;
	localparam int RAND_PER_PHASE = 250;

	typedef struct {
		logic [LEAF_PORT_W-1:0]  leaf;
		logic [COUNT_PORT_W-1:0] count;
		logic                    ovf;
		logic                    drain;
	} oram_result_t;

	typedef struct {
		logic [1:0]            f;
		logic [BLOCK_ID_W-1:0] blk;
		logic [LEAF_PORT_W-1:0] nl;
		bit                    typed;
		oram_result_t          res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic cfg_index = 1'b0;
	logic [THRESH_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = '0;
	logic [BLOCK_ID_W-1:0] block_id = '0;
	logic [LEAF_PORT_W-1:0] new_leaf = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [LEAF_PORT_W-1:0] path_leaf;
	logic [COUNT_PORT_W-1:0] stash_count;
	logic stash_overflow;
	logic dummy_needed;

	path_oram_access_controller dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .block_id(block_id), .new_leaf(new_leaf),
		.out_valid(out_valid), .out_ready(out_ready),
		.path_leaf(path_leaf), .stash_count(stash_count),
		.stash_overflow(stash_overflow), .dummy_needed(dummy_needed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the tree, position map and stash
	logic [BLOCK_ID_W-1:0] tree_slot [NODES][SLOTS];
	int tree_fill [NODES];
	logic [LEAF_PORT_W-1:0] pos_map [256];
	logic [BLOCK_ID_W-1:0] stash_q [$];
	bit shadow_drain;
	int upper_th = UPPER_RESET;
	int lower_th = LOWER_RESET;
	bit shadow_dropped;

	bit placed [256];
	logic [BLOCK_ID_W-1:0] placed_list [$];

	oram_result_t pending_q [$];
	int mismatches = 0;
	int sent = 0, received = 0, overflows_seen = 0, drains_seen = 0;
	int tx_idle = 0, rx_idle = 0;
	int holdoff_req = 0;
	int holdoff_left = 0;
	logic [LEAF_PORT_W-1:0] hot_leaf;
	bit hot_mode = 0;

	function automatic int node_at(int lv, int leaf);
		return ((1 << lv) - 1) + (leaf >> (LEVELS - 1 - lv));
	endfunction

	task automatic stash_add(logic [BLOCK_ID_W-1:0] b);
		if (stash_q.size() >= STASH_MAX)
			shadow_dropped = 1;
		else
			stash_q.insert(stash_q.size(), b);
	endtask

	task automatic evict_along(int leaf);
		int sh, n, k;
		logic [BLOCK_ID_W-1:0] b;
		for (int lv = LEVELS - 1; lv >= 0; lv--) begin
			sh = LEVELS - 1 - lv;
			n = node_at(lv, leaf);
			k = 0;
			while (k < stash_q.size() && tree_fill[n] < SLOTS) begin
				b = stash_q[k];
				if ((int'(pos_map[b]) >> sh) == (leaf >> sh)) begin
					tree_slot[n][tree_fill[n]] = b;
					tree_fill[n]++;
					stash_q.delete(k);
				end else begin
					k++;
				end
			end
		end
	endtask

	task automatic oram_predict(input logic [1:0] f, input logic [BLOCK_ID_W-1:0] b,
			input logic [LEAF_PORT_W-1:0] nl, output oram_result_t r);
		int path, n;
		path = 0;
		shadow_dropped = 0;
		if (f == FUNC_INSTALL) begin
			pos_map[b] = nl;
			path = nl;
			stash_add(b);
			evict_along(path);
		end else if (f == FUNC_ACCESS || f == FUNC_DUMMY) begin
			path = pos_map[b];
			for (int lv = LEVELS - 1; lv >= 0; lv--) begin
				n = node_at(lv, path);
				for (int s = 0; s < tree_fill[n]; s++)
					stash_add(tree_slot[n][s]);
				tree_fill[n] = 0;
			end
			if (f == FUNC_ACCESS)
				pos_map[b] = nl;
			evict_along(path);
		end
		if (stash_q.size() > upper_th)
			shadow_drain = 1;
		else if (stash_q.size() <= lower_th)
			shadow_drain = 0;
		r.leaf = LEAF_PORT_W'(path);
		r.count = COUNT_PORT_W'(stash_q.size());
		r.ovf = shadow_dropped;
		r.drain = shadow_drain;
	endtask

	// one input transaction; in_valid stays high across back-to-back items
	task automatic issue(input logic [1:0] f, input logic [BLOCK_ID_W-1:0] b,
			input logic [LEAF_PORT_W-1:0] nl, input bit typed, input oram_result_t tr);
		oram_result_t pr;
		if ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		block_id <= b;
		new_leaf <= nl;
		do @(posedge clk); while (!in_ready);
		oram_predict(f, b, nl, pr);
		pending_q.insert(pending_q.size(), typed ? tr : pr);
		sent++;
		if (f == FUNC_INSTALL && !placed[b]) begin
			placed[b] = 1;
			placed_list.insert(placed_list.size(), b);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_thresholds(int up, int lo);
		cfg_write <= 1'b1;
		cfg_index <= CFG_UPPER;
		cfg_data <= THRESH_W'(up);
		@(posedge clk);
		cfg_index <= CFG_LOWER;
		cfg_data <= THRESH_W'(lo);
		@(posedge clk);
		cfg_write <= 1'b0;
		upper_th = up;
		lower_th = lo;
	endtask

	task automatic random_item();
		int r;
		logic [1:0] f;
		logic [BLOCK_ID_W-1:0] b;
		logic [LEAF_PORT_W-1:0] nl;
		oram_result_t none;
		r = $urandom_range(99);
		b = BLOCK_ID_W'($urandom);
		nl = LEAF_PORT_W'($urandom);
		if (r < 3) begin
			f = FUNC_UNUSED;
		end else if (r < 25 || placed_list.size() == 0 || hot_mode) begin
			f = FUNC_INSTALL;
			// piling installs onto one leaf overfills its path and the stash
			if (hot_mode)
				nl = hot_leaf;
		end else begin
			f = (r < 70) ? FUNC_ACCESS : FUNC_DUMMY;
			b = placed_list[$urandom_range(placed_list.size() - 1)];
		end
		issue(f, b, nl, 0, none);
	endtask

	always @(posedge clk) begin
		if (holdoff_req > 0) begin
			holdoff_left = holdoff_req;
			holdoff_req = 0;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		oram_result_t e;
		if (arst_n && out_valid && out_ready) begin
			received++;
			if (stash_overflow) overflows_seen++;
			if (dummy_needed) drains_seen++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: leaf %0d count %0d",
						path_leaf, stash_count);
			end else begin
				e = pending_q.pop_front();
				if (path_leaf !== e.leaf || stash_count !== e.count ||
						stash_overflow !== e.ovf || dummy_needed !== e.drain) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp leaf %0d count %0d ovf %0b drain %0b, got %0d %0d %0b %0b",
							e.leaf, e.count, e.ovf, e.drain,
							path_leaf, stash_count, stash_overflow, dummy_needed);
				end
			end
		end
	end

	initial begin
		#200_000_000;
		$display("** path_oram_access_controller: FAILED **");
		$finish;
	end

	initial begin
		dir_row_t dir [18];
		int ups [4];
		int los [4];
		for (int n = 0; n < NODES; n++) tree_fill[n] = 0;
		for (int i = 0; i < 256; i++) placed[i] = 0;
		dir[0]  = '{FUNC_INSTALL, 8'd0,   7'd0,   1, '{7'd0,   7'd0, 1'b0, 1'b0}};
		dir[1]  = '{FUNC_INSTALL, 8'd255, 7'd127, 1, '{7'd127, 7'd0, 1'b0, 1'b0}};
		dir[2]  = '{FUNC_UNUSED,  8'd7,   7'd5,   1, '{7'd0,   7'd0, 1'b0, 1'b0}};
		dir[3]  = '{FUNC_ACCESS,  8'd0,   7'd127, 1, '{7'd0,   7'd0, 1'b0, 1'b0}};
		dir[4]  = '{FUNC_DUMMY,   8'd255, 7'd0,   1, '{7'd127, 7'd0, 1'b0, 1'b0}};
		dir[5]  = '{FUNC_ACCESS,  8'd0,   7'd0,   1, '{7'd127, 7'd0, 1'b0, 1'b0}};
		dir[6]  = '{FUNC_INSTALL, 8'hAA,  7'h55,  1, '{7'h55,  7'd0, 1'b0, 1'b0}};
		dir[7]  = '{FUNC_INSTALL, 8'h55,  7'h2A,  1, '{7'h2A,  7'd0, 1'b0, 1'b0}};
		dir[8]  = '{FUNC_ACCESS,  8'hAA,  7'd3,   1, '{7'h55,  7'd0, 1'b0, 1'b0}};
		dir[9]  = '{FUNC_DUMMY,   8'h55,  7'h7F,  1, '{7'h2A,  7'd0, 1'b0, 1'b0}};
		for (int i = 10; i < 16; i++)
			dir[i] = '{FUNC_INSTALL, 8'(i), 7'd9, 0, '{0, 0, 0, 0}};
		dir[16] = '{FUNC_ACCESS,  8'd10,  7'd100, 0, '{0, 0, 0, 0}};
		dir[17] = '{FUNC_UNUSED,  8'd255, 7'd127, 0, '{0, 0, 0, 0}};
		ups = '{48, 0, 64, 20};
		los = '{16, 0, 0, 10};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// the block clears the tree after reset before it takes transactions
		do @(posedge clk); while (!in_ready);

		for (int p = 0; p < 4; p++) begin
			set_thresholds(ups[p], los[p]);
			tx_idle = (p == 0) ? 32 : (p == 1) ? 82 : 0;
			rx_idle = (p == 0) ? 82 : (p == 1) ? 32 : 0;
			if (p == 0)
				foreach (dir[i])
					issue(dir[i].f, dir[i].blk, dir[i].nl, dir[i].typed, dir[i].res);
			if (p == 2)
				holdoff_req = 3000;
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				hot_mode = (p == 0 && i >= 20 && i < 100);
				if (i == 20) hot_leaf = LEAF_PORT_W'($urandom);
				random_item();
			end
			hot_mode = 0;
			wait_drained();
		end

		repeat (50) @(posedge clk);
		$display("sent %0d transactions, checked %0d results over 4 threshold settings",
			sent, received);
		$display("results with stash overflow: %0d, with dummy reads requested: %0d",
			overflows_seen, drains_seen);
		if (mismatches == 0 && pending_q.size() == 0)
			$display("** path_oram_access_controller: PASSED **");
		else
			$display("** path_oram_access_controller: FAILED **");
		$finish;
	end

endmodule

[path_oram_access_controller.f]
rtl/poac_pkg.sv
rtl/poac_ctrl.sv
rtl/poac_datapath.sv
rtl/path_oram_access_controller.sv
tb/sv/path_oram_access_controller_tb.sv
